FILE: src/ulaq_pkg.sv
// ----------------------------------------------------------------------------
// UART line assembler queue: shared definitions
// Action codes, byte codes and the command and result records passed between
// the front end, the engine and the result queue.
// ----------------------------------------------------------------------------
package ulaq_pkg;

   localparam logic [1:0] ACT_RECEIVE   = 2'd0;
   localparam logic [1:0] ACT_TAKE_LINE = 2'd1;
   localparam logic [1:0] ACT_TAKE_RAW  = 2'd2;
   localparam logic [1:0] ACT_CLEAR_RAW = 2'd3;

   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_CR = 8'h0D;

   // The lines_waiting field saturates at this value.
   localparam logic [2:0] WAIT_MAX = 3'd7;

   // Command queue between front end and engine.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;

   // Result queue at the output.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   typedef struct packed {
      logic       is_recv;
      logic       is_line;
      logic       is_raw;
      logic       is_clear;
      logic       is_term;
      logic [7:0] rx_byte;
      logic [5:0] raw_max;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic [2:0] lines_waiting;
   } rsp_type;

endpackage

FILE: src/ulaq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ulaq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ulaq_front.sv
// ----------------------------------------------------------------------------
// Front end
// Accepts request beats, decodes the action and holds up to two commands
// for the engine.
// ----------------------------------------------------------------------------
module ulaq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_rx_byte,
   input  logic [5:0]        req_raw_max,
   output logic              cmd_valid,
   output ulaq_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   ulaq_pkg::cmd_type                 slot_ff [ulaq_pkg::CMD_DEPTH];
   logic [ulaq_pkg::CMD_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ulaq_pkg::CMD_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ulaq_pkg::CMD_CNT_W-1:0]    count_ff, count_in;
   ulaq_pkg::cmd_type                 decoded;
   logic                              do_push;
   logic                              do_pop;

   always_comb begin
      decoded          = '0;
      decoded.rx_byte  = req_rx_byte;
      decoded.raw_max  = req_raw_max;
      decoded.is_term  = (req_rx_byte == ulaq_pkg::BYTE_LF) ||
                         (req_rx_byte == ulaq_pkg::BYTE_CR);
      case (req_action)
         ulaq_pkg::ACT_RECEIVE:   decoded.is_recv  = 1'b1;
         ulaq_pkg::ACT_TAKE_LINE: decoded.is_line  = 1'b1;
         ulaq_pkg::ACT_TAKE_RAW:  decoded.is_raw   = 1'b1;
         ulaq_pkg::ACT_CLEAR_RAW: decoded.is_clear = 1'b1;
         default:                 decoded.is_clear = 1'b1;
      endcase
   end

   assign req_full  = (count_ff == ulaq_pkg::CMD_CNT_W'(ulaq_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

FILE: src/ulaq_back.sv
// ----------------------------------------------------------------------------
// Engine
// Carries out commands: stores received bytes in the raw ring, assembles
// lines straight into the line store and streams taken bytes to the output.
// ----------------------------------------------------------------------------
module ulaq_back #(
   parameter int LINE_BYTES  = 64,
   parameter int QUEUE_LINES = 4,
   parameter int RAW_BYTES   = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  ulaq_pkg::cmd_type                cmd,
   output logic                             cmd_pop,
   input  logic [ulaq_pkg::OUT_CNT_W-1:0]   rsp_level,
   output logic                             rsp_push,
   output ulaq_pkg::rsp_type                rsp
);

   localparam int LEN_W      = $clog2(LINE_BYTES);
   // One spare slot, so the line being built never overlays a queued line.
   localparam int SLOTS      = QUEUE_LINES + 1;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(QUEUE_LINES + 1);
   localparam int RAW_W      = $clog2(RAW_BYTES);
   localparam int LINE_AW    = SLOT_W + LEN_W;
   localparam int LINE_DEPTH = SLOTS * (2 ** LEN_W);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_NULL = 2'd1;
   localparam logic [1:0] S_LINE = 2'd2;
   localparam logic [1:0] S_RAW  = 2'd3;

   localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(LINE_BYTES - 1);
   localparam logic [CNT_W-1:0]  COUNT_FULL = CNT_W'(QUEUE_LINES);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);
   localparam logic [RAW_W-1:0]  RAW_LAST   = RAW_W'(RAW_BYTES - 1);

   logic [1:0]        state_ff, state_in;
   logic [RAW_W-1:0]  raw_head_ff, raw_head_in;
   logic [RAW_W-1:0]  raw_tail_ff, raw_tail_in;
   logic [LEN_W-1:0]  build_len_ff, build_len_in;
   logic              build_ovf_ff, build_ovf_in;
   logic [SLOT_W-1:0] q_head_ff, q_head_in;
   logic [SLOT_W-1:0] q_tail_ff, q_tail_in;
   logic [CNT_W-1:0]  q_count_ff, q_count_in;
   logic [LEN_W-1:0]  len_ff [SLOTS];
   logic [SLOT_W-1:0] take_slot_ff, take_slot_in;
   logic [LEN_W-1:0]  take_len_ff, take_len_in;
   logic [LEN_W-1:0]  take_idx_ff, take_idx_in;
   logic [5:0]        raw_left_ff, raw_left_in;

   logic              p_valid_ff, p_valid_in;
   logic              p_mem_ff, p_mem_in;
   logic              p_line_ff, p_line_in;
   logic              p_last_ff, p_last_in;
   logic [2:0]        p_wait_ff, p_wait_in;

   logic              len_we;
   logic              raw_we, raw_re;
   logic              line_we, line_re;
   logic [7:0]        raw_rdata, line_rdata;
   logic              space;
   logic              last;
   logic [CNT_W+2:0]  count_wide;
   logic [2:0]        wait_now;

   function automatic logic [RAW_W-1:0] raw_next(input logic [RAW_W-1:0] i);
      return (i == RAW_LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] i);
      return (i == SLOT_LAST) ? '0 : i + 1'b1;
   endfunction

   assign count_wide = (CNT_W + 3)'(q_count_ff);
   assign wait_now   = (count_wide > (CNT_W + 3)'(ulaq_pkg::WAIT_MAX)) ?
                       ulaq_pkg::WAIT_MAX : count_wide[2:0];

   // The beat in the read stage already holds one place in the result queue.
   assign space = p_valid_ff ?
                  (rsp_level < ulaq_pkg::OUT_CNT_W'(ulaq_pkg::OUT_DEPTH - 1)) :
                  (rsp_level < ulaq_pkg::OUT_CNT_W'(ulaq_pkg::OUT_DEPTH));

   always_comb begin
      state_in     = state_ff;
      raw_head_in  = raw_head_ff;
      raw_tail_in  = raw_tail_ff;
      build_len_in = build_len_ff;
      build_ovf_in = build_ovf_ff;
      q_head_in    = q_head_ff;
      q_tail_in    = q_tail_ff;
      q_count_in   = q_count_ff;
      take_slot_in = take_slot_ff;
      take_len_in  = take_len_ff;
      take_idx_in  = take_idx_ff;
      raw_left_in  = raw_left_ff;
      p_valid_in   = 1'b0;
      p_mem_in     = p_mem_ff;
      p_line_in    = p_line_ff;
      p_last_in    = p_last_ff;
      p_wait_in    = wait_now;
      cmd_pop      = 1'b0;
      len_we       = 1'b0;
      raw_we       = 1'b0;
      raw_re       = 1'b0;
      line_we      = 1'b0;
      line_re      = 1'b0;
      last         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.is_recv) begin
                  raw_we      = 1'b1;
                  raw_head_in = raw_next(raw_head_ff);
                  if (raw_next(raw_head_ff) == raw_tail_ff) begin
                     raw_tail_in = raw_next(raw_tail_ff);
                  end
                  if (cmd.is_term) begin
                     if (build_len_ff != '0) begin
                        len_we    = 1'b1;
                        q_head_in = slot_next(q_head_ff);
                        if (q_count_ff == COUNT_FULL) begin
                           q_tail_in = slot_next(q_tail_ff);
                        end else begin
                           q_count_in = q_count_ff + 1'b1;
                        end
                     end
                     build_len_in = '0;
                     build_ovf_in = 1'b0;
                  end else if (!build_ovf_ff) begin
                     if (build_len_ff < LEN_MAX) begin
                        line_we      = 1'b1;
                        build_len_in = build_len_ff + 1'b1;
                     end else begin
                        build_ovf_in = 1'b1;
                     end
                  end
               end else if (cmd.is_clear) begin
                  raw_head_in = '0;
                  raw_tail_in = '0;
               end else if (cmd.is_line) begin
                  if (q_count_ff == '0) begin
                     state_in = S_NULL;
                  end else begin
                     take_slot_in = q_tail_ff;
                     take_len_in  = len_ff[q_tail_ff];
                     take_idx_in  = '0;
                     q_tail_in    = slot_next(q_tail_ff);
                     q_count_in   = q_count_ff - 1'b1;
                     state_in     = S_LINE;
                  end
               end else begin
                  if ((raw_tail_ff == raw_head_ff) || (cmd.raw_max == '0)) begin
                     state_in = S_NULL;
                  end else begin
                     raw_left_in = cmd.raw_max;
                     state_in    = S_RAW;
                  end
               end
            end
         end
         S_NULL: begin
            if (space) begin
               p_valid_in = 1'b1;
               p_mem_in   = 1'b0;
               p_last_in  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_LINE: begin
            if (space) begin
               last        = ((LEN_W + 1)'(take_idx_ff) + 1'b1) ==
                             (LEN_W + 1)'(take_len_ff);
               line_re     = 1'b1;
               p_valid_in  = 1'b1;
               p_mem_in    = 1'b1;
               p_line_in   = 1'b1;
               p_last_in   = last;
               take_idx_in = take_idx_ff + 1'b1;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_RAW: begin
            if (space) begin
               last        = (raw_left_ff == 6'd1) ||
                             (raw_next(raw_tail_ff) == raw_head_ff);
               raw_re      = 1'b1;
               p_valid_in  = 1'b1;
               p_mem_in    = 1'b1;
               p_line_in   = 1'b0;
               p_last_in   = last;
               raw_tail_in = raw_next(raw_tail_ff);
               raw_left_in = raw_left_ff - 1'b1;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         raw_head_ff  <= '0;
         raw_tail_ff  <= '0;
         build_len_ff <= '0;
         build_ovf_ff <= 1'b0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         q_count_ff   <= '0;
         p_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_head_ff  <= raw_head_in;
         raw_tail_ff  <= raw_tail_in;
         build_len_ff <= build_len_in;
         build_ovf_ff <= build_ovf_in;
         q_head_ff    <= q_head_in;
         q_tail_ff    <= q_tail_in;
         q_count_ff   <= q_count_in;
         p_valid_ff   <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      take_slot_ff <= take_slot_in;
      take_len_ff  <= take_len_in;
      take_idx_ff  <= take_idx_in;
      raw_left_ff  <= raw_left_in;
      p_mem_ff     <= p_mem_in;
      p_line_ff    <= p_line_in;
      p_last_ff    <= p_last_in;
      p_wait_ff    <= p_wait_in;
      if (len_we) begin
         len_ff[q_head_ff] <= build_len_ff;
      end
   end

   ulaq_ram #(
      .WIDTH (8),
      .DEPTH (RAW_BYTES)
   ) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_we),
      .wr_addr (raw_head_ff),
      .wr_data (cmd.rx_byte),
      .rd_en   (raw_re),
      .rd_addr (raw_tail_ff),
      .rd_data (raw_rdata)
   );

   ulaq_ram #(
      .WIDTH (8),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (LINE_AW'({q_head_ff, build_len_ff})),
      .wr_data (cmd.rx_byte),
      .rd_en   (line_re),
      .rd_addr (LINE_AW'({take_slot_ff, take_idx_ff})),
      .rd_data (line_rdata)
   );

   always_comb begin
      rsp_push          = p_valid_ff;
      rsp.out_valid     = p_mem_ff;
      rsp.out_last      = p_last_ff;
      rsp.lines_waiting = p_wait_ff;
      if (!p_mem_ff) begin
         rsp.out_byte = 8'h00;
      end else if (p_line_ff) begin
         rsp.out_byte = line_rdata;
      end else begin
         rsp.out_byte = raw_rdata;
      end
   end

endmodule

FILE: src/ulaq_rsp_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Holds finished result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module ulaq_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  ulaq_pkg::rsp_type              push_data,
   output logic [ulaq_pkg::OUT_CNT_W-1:0] level,
   input  logic                           pop,
   output logic                           empty,
   output ulaq_pkg::rsp_type              head
);

   ulaq_pkg::rsp_type                 slot_ff [ulaq_pkg::OUT_DEPTH];
   logic [ulaq_pkg::OUT_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ulaq_pkg::OUT_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ulaq_pkg::OUT_CNT_W-1:0]    count_ff, count_in;
   logic                              do_pop;

   assign empty  = (count_ff == '0);
   assign level  = count_ff;
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   // The engine never pushes into a full queue, as it counts its own beat in flight.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/uart_line_assembler_queue_top.sv
// ----------------------------------------------------------------------------
// UART line assembler queue
// Receive bytes go to a raw ring and a line assembler; take requests stream a
// queued line or raw bytes out as result beats.
// ----------------------------------------------------------------------------
// Receive and clear requests pass through the front-end queue and take effect
// when the idle engine pops them; the idle engine carries out one per cycle.
// A take holds the engine until its last beat is read. Its first beat passes the
// front-end slot, engine state, read stage and result queue registers before the
// result ports, and one beat follows per cycle while the result queue has room.
// Synchronous reset empties all queues and pointers; RAM contents need no clearing.
module uart_line_assembler_queue_top #(
   parameter int LINE_BYTES  = 64,
   parameter int QUEUE_LINES = 4,
   parameter int RAW_BYTES   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_action,
   input  logic [7:0] req_rx_byte,
   input  logic [5:0] req_raw_max,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last,
   output logic [2:0] rsp_lines_waiting
);

   logic                           cmd_valid;
   logic                           cmd_pop;
   ulaq_pkg::cmd_type              cmd;
   logic                           rsp_push;
   ulaq_pkg::rsp_type              rsp_in;
   ulaq_pkg::rsp_type              rsp_head;
   logic [ulaq_pkg::OUT_CNT_W-1:0] rsp_level;

   ulaq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_action  (req_action),
      .req_rx_byte (req_rx_byte),
      .req_raw_max (req_raw_max),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   ulaq_back #(
      .LINE_BYTES  (LINE_BYTES),
      .QUEUE_LINES (QUEUE_LINES),
      .RAW_BYTES   (RAW_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   ulaq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .level     (rsp_level),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_out_byte      = rsp_head.out_byte;
   assign rsp_out_valid     = rsp_head.out_valid;
   assign rsp_out_last      = rsp_head.out_last;
   assign rsp_lines_waiting = rsp_head.lines_waiting;

endmodule
